// File: hdl/cchash_pkg.sv
// cchash_pkg: status codes, coordinate limits and the command/status structs
// shared by the chunk coordinate hash table controller, datapath and top level.
// no dependencies.
`default_nettype none

package cchash_pkg;

	localparam int COORD_W  = 26;
	localparam int STATUS_W = 3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	// coordinates must lie strictly inside +/- this margin
	localparam logic signed [COORD_W-1:0] SAFE_MARGIN = 26'sd33554431;

	// source of the reported entry index
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_CUR  = 2'd1;
	localparam logic [1:0] SEL_NODE = 2'd2;

	typedef struct packed {
		logic                clr_wr;
		logic                load;
		logic                rd_head;
		logic                rd_link;
		logic                wr_claim_cur;
		logic                wr_link_cur;
		logic                wr_claim_node;
		logic                emit;
		logic [STATUS_W-1:0] code;
		logic [1:0]          idx_sel;
	} cchash_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic range_ok;
		logic insert;
		logic hit;
		logic entry_valid;
		logic link_zero;
		logic pool_full;
	} cchash_sts_t;

endpackage

`default_nettype wire

// File: hdl/cchash_ram.sv
// cchash_ram: generic simple dual-port ram, one write and one registered read port.
// no dependencies.
`default_nettype none

module cchash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/cchash_ctrl.sv
// cchash_ctrl: state machine for the chunk coordinate hash table; clearing sweep,
// chain walk and insert sequencing. depends on cchash_pkg.
`default_nettype none

module cchash_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire cchash_pkg::cchash_sts_t sts,
	output cchash_pkg::cchash_cmd_t      cmd
);

	import cchash_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_NODE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code    = ST_ABSENT;
		cmd.idx_sel = SEL_ZERO;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				if (!sts.range_ok) begin
					cmd.emit = 1'b1;
					cmd.code = ST_RANGE;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.hit) begin
					cmd.emit    = 1'b1;
					cmd.code    = ST_FOUND;
					cmd.idx_sel = SEL_CUR;
					state_d     = S_IDLE;
				end else if (sts.insert && !sts.entry_valid) begin
					cmd.wr_claim_cur = 1'b1;
					cmd.emit         = 1'b1;
					cmd.code         = ST_INSERTED;
					cmd.idx_sel      = SEL_CUR;
					state_d          = S_IDLE;
				end else if (sts.insert && sts.link_zero) begin
					if (sts.pool_full) begin
						cmd.emit = 1'b1;
						cmd.code = ST_POOL_FULL;
						state_d  = S_IDLE;
					end else begin
						// link the tail to a fresh pool node, claim it next cycle
						cmd.wr_link_cur = 1'b1;
						state_d         = S_NODE;
					end
				end else if (sts.link_zero) begin
					cmd.emit = 1'b1;
					cmd.code = ST_ABSENT;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_link = 1'b1;
				end
			end
			S_NODE: begin
				cmd.wr_claim_node = 1'b1;
				cmd.emit          = 1'b1;
				cmd.code          = ST_INSERTED;
				cmd.idx_sel       = SEL_NODE;
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/cchash_dp.sv
// cchash_dp: datapath of the chunk coordinate hash table; request registers, hash,
// entry store, pool allocator and result registers. depends on cchash_pkg, cchash_ram.
`default_nettype none

module cchash_dp #(
	parameter int HASH_SLOTS   = 4096,
	parameter int POOL_ENTRIES = 1024
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                opcode,
	input  wire logic signed [cchash_pkg::COORD_W-1:0]               chunk_x,
	input  wire logic signed [cchash_pkg::COORD_W-1:0]               chunk_y,
	input  wire cchash_pkg::cchash_cmd_t                             cmd,
	output cchash_pkg::cchash_sts_t                                  sts,
	output logic                                                     done,
	output logic [cchash_pkg::STATUS_W-1:0]                          status,
	output logic [$clog2(HASH_SLOTS+POOL_ENTRIES)-1:0]               entry_index
);

	import cchash_pkg::*;

	localparam int TOTAL  = HASH_SLOTS + POOL_ENTRIES;
	localparam int IDX_W  = $clog2(TOTAL);
	localparam int HASH_W = $clog2(HASH_SLOTS);
	localparam int PCNT_W = $clog2(POOL_ENTRIES + 1);
	localparam int WORD_W = 1 + IDX_W + 2 * COORD_W;

	logic                      insert_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic [IDX_W-1:0]          cur_q;
	logic [IDX_W-1:0]          node_q;
	logic [IDX_W-1:0]          clr_q;
	logic [PCNT_W-1:0]         pool_cnt_q;
	logic                      done_q;
	logic [STATUS_W-1:0]       status_q;
	logic [IDX_W-1:0]          index_q;

	logic [31:0]        xw;
	logic [31:0]        yw;
	logic [31:0]        hash;
	logic [IDX_W-1:0]   head;
	logic [IDX_W-1:0]   node;
	logic [WORD_W-1:0]  rdata;
	logic [WORD_W-1:0]  wdata;
	logic [IDX_W-1:0]   waddr;
	logic               we;
	logic [IDX_W-1:0]   raddr;
	logic               rd_valid;
	logic [IDX_W-1:0]   rd_link;
	logic [COORD_W-1:0] rd_col;
	logic [COORD_W-1:0] rd_row;

	// 19*x + 7*y mod 2^32 as shifts and adds
	assign xw   = {{(32-COORD_W){x_q[COORD_W-1]}}, x_q};
	assign yw   = {{(32-COORD_W){y_q[COORD_W-1]}}, y_q};
	assign hash = (xw << 4) + (xw << 1) + xw + (yw << 2) + (yw << 1) + yw;
	assign head = IDX_W'(hash[HASH_W-1:0]);
	assign node = IDX_W'(HASH_SLOTS) + IDX_W'(pool_cnt_q);

	// entry word: {valid, link, col, row}
	assign rd_valid = rdata[WORD_W-1];
	assign rd_link  = rdata[WORD_W-2 -: IDX_W];
	assign rd_col   = rdata[2*COORD_W-1 -: COORD_W];
	assign rd_row   = rdata[COORD_W-1:0];

	assign we    = cmd.clr_wr | cmd.wr_claim_cur | cmd.wr_link_cur | cmd.wr_claim_node;
	assign raddr = cmd.rd_head ? head : rd_link;

	always_comb begin
		waddr = cur_q;
		wdata = {1'b1, {IDX_W{1'b0}}, x_q, y_q};
		if (cmd.clr_wr) begin
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.wr_link_cur) begin
			wdata = {rd_valid, node, rd_col, rd_row};
		end else if (cmd.wr_claim_node) begin
			waddr = node_q;
		end
	end

	cchash_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TOTAL)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_head | cmd.rd_link),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts             = '0;
		sts.clr_last    = (clr_q == IDX_W'(TOTAL - 1));
		sts.range_ok    = (x_q > -SAFE_MARGIN) && (x_q < SAFE_MARGIN) &&
		                  (y_q > -SAFE_MARGIN) && (y_q < SAFE_MARGIN);
		sts.insert      = insert_q;
		sts.entry_valid = rd_valid;
		sts.hit         = rd_valid && (rd_col == x_q) && (rd_row == y_q);
		sts.link_zero   = (rd_link == '0);
		sts.pool_full   = (pool_cnt_q >= PCNT_W'(POOL_ENTRIES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			pool_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.wr_link_cur) begin
				pool_cnt_q <= pool_cnt_q + 1'b1;
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			insert_q <= opcode;
			x_q      <= chunk_x;
			y_q      <= chunk_y;
		end
		if (cmd.rd_head) begin
			cur_q <= head;
		end else if (cmd.rd_link) begin
			cur_q <= rd_link;
		end
		if (cmd.wr_link_cur) begin
			node_q <= node;
		end
		if (cmd.emit) begin
			status_q <= cmd.code;
			case (cmd.idx_sel)
				SEL_CUR:  index_q <= cur_q;
				SEL_NODE: index_q <= node_q;
				default:  index_q <= '0;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = index_q;

endmodule

`default_nettype wire

// File: hdl/chunk_coordinate_hash_table.sv
// chunk_coordinate_hash_table: top level; chained hash table of 2-D chunk coordinates.
// depends on cchash_pkg, cchash_ctrl, cchash_dp (and cchash_ram below it).
//
// usage: drive opcode (0 lookup, 1 lookup or insert), chunk_x and chunk_y and raise
// start; the transaction is taken at a rising edge with start high and busy low.
// busy stays high until the result is decided. the result appears on status and
// entry_index for exactly one cycle, flagged by done; there is no backpressure, the
// receiver must take it in that cycle. a new start may be given in the done cycle.
// from accept to done: S_LOOK checks the range (out of range is decided there) and
// reads the head slot, S_EVAL decides or reads the next chain node, S_NODE claims
// a linked pool node, and done is registered from the deciding state. the entry
// store is one ram with a single write and a single registered read port, so each
// chain step costs one read and the pool insert costs two writes.
// reset: after arst_n is released a clearing pass writes every entry of the store,
// HASH_SLOTS + POOL_ENTRIES entries (5120 at the defaults), with busy held high.
`default_nettype none

module chunk_coordinate_hash_table #(
	parameter int HASH_SLOTS   = 4096,
	parameter int POOL_ENTRIES = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   opcode,
	input  wire logic signed [cchash_pkg::COORD_W-1:0]  chunk_x,
	input  wire logic signed [cchash_pkg::COORD_W-1:0]  chunk_y,
	output logic                                        done,
	output logic [cchash_pkg::STATUS_W-1:0]             status,
	output logic [$clog2(HASH_SLOTS+POOL_ENTRIES)-1:0]  entry_index
);

	import cchash_pkg::*;

	localparam int TOTAL = HASH_SLOTS + POOL_ENTRIES;
	localparam int IDX_W = $clog2(TOTAL);

	cchash_cmd_t cmd;
	cchash_sts_t sts;

	cchash_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	cchash_dp #(
		.HASH_SLOTS  (HASH_SLOTS),
		.POOL_ENTRIES(POOL_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.chunk_x    (chunk_x),
		.chunk_y    (chunk_y),
		.cmd        (cmd),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.entry_index(entry_index)
	);

`ifndef NO_ASSERTIONS
	// a result only follows a transaction in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// at most one store write per cycle
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.wr_claim_cur, cmd.wr_link_cur, cmd.wr_claim_node}))
		else $error("conflicting store writes");

	// never hand out a pool node past the end of the pool
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_link_cur |-> !sts.pool_full)
		else $error("pool node allocated while pool is full");

	// reported entry lies inside the store
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_index < IDX_W'(TOTAL)))
		else $error("entry index outside the store");
`endif

endmodule

`default_nettype wire
